FILE: hw/rtl/bec_pkg.sv
`default_nettype none

package bec_pkg;

  // Field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned CfgIdxW = 2;

  // Register defaults after reset
  localparam logic [CfgW-1:0] ClickWindowRst = 16'd250;
  localparam logic [CfgW-1:0] HoldDelayRst   = 16'd1000;
  localparam logic [CfgW-1:0] RepeatRst      = 16'd200;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLICK_WINDOW = 2'd0,
    CFG_HOLD_DELAY   = 2'd1,
    CFG_REPEAT       = 2'd2
  } cfg_idx_e;

  // Event codes
  typedef enum logic [CodeW-1:0] {
    EV_PRESSED  = 3'd0,
    EV_CLICKED  = 3'd1,
    EV_RELEASED = 3'd2,
    EV_HELD     = 3'd3,
    EV_REPEAT   = 3'd4
  } event_e;

  // Timing settings handed to the classifier
  typedef struct packed {
    logic [CfgW-1:0] click_window;
    logic [CfgW-1:0] hold_delay;
    logic [CfgW-1:0] repeat_period;
  } cfg_t;

  // Decision for one poll
  typedef struct packed {
    logic   hit;
    event_e code;
  } decision_t;

endpackage

`default_nettype wire

FILE: hw/rtl/button_event_classifier.sv
// An event shows on out_valid_o once its poll has passed the input register
// and then the result register.
// Throughput: one poll per cycle unless out_stall_i blocks an event; the single
// classification stage updates button state in the same cycle it decides, so
// polls follow back to back. Polls that cause no event are dropped inside.
// Reset (rst_ni low, asynchronous): pipeline empty, button not pressed and
// not holding, last event time 0, registers at 250 / 1000 / 200 ms.
`default_nettype none

module button_event_classifier
  import bec_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Poll channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [TimeW-1:0]   time_ms_i,
  input  wire logic               level_i,
  input  wire logic               edge_seen_i,
  // Event channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [CodeW-1:0]        event_code_o,
  output logic                    event_level_o,
  // Configuration writes
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i
);

  cfg_t             cfg;
  decision_t        dec;
  logic             s1_valid_q;
  logic [TimeW-1:0] s1_time_q;
  logic             s1_level_q;
  logic             s1_edge_q;
  logic             out_valid_q;
  event_e           out_code_q;
  logic             out_level_q;
  logic             out_free;
  logic             s1_adv;
  logic             s1_load;

  bec_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Output register can take a new event this cycle
  assign out_free = !out_valid_q || !out_stall_i;
  // Stage 1 request moves on when its event (if any) has room
  assign s1_adv   = s1_valid_q && (out_free || !dec.hit);
  assign s1_load  = !s1_valid_q || s1_adv;
  assign in_stall_o = !s1_load;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      s1_time_q  <= time_ms_i;
      s1_level_q <= level_i;
      s1_edge_q  <= edge_seen_i;
    end
  end

  bec_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (s1_valid_q),
    .commit_i    (s1_adv),
    .time_ms_i   (s1_time_q),
    .level_i     (s1_level_q),
    .edge_seen_i (s1_edge_q),
    .dec_o       (dec)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q && dec.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q && dec.hit) begin
      out_code_q  <= dec.code;
      out_level_q <= s1_level_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_code_o  = out_code_q;
  assign event_level_o = out_level_q;

  // Input side only backs up behind a full, stalled result register
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i && s1_valid_q && dec.hit)
    else $error("poll stalled without a blocked event");

endmodule

`default_nettype wire

FILE: hw/rtl/bec_cfg_regs.sv
`default_nettype none

module bec_cfg_regs
  import bec_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q;

  // Register file; writes to unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.click_window  <= ClickWindowRst;
      cfg_q.hold_delay    <= HoldDelayRst;
      cfg_q.repeat_period <= RepeatRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CLICK_WINDOW: cfg_q.click_window  <= cfg_wdata_i;
        CFG_HOLD_DELAY:   cfg_q.hold_delay    <= cfg_wdata_i;
        CFG_REPEAT:       cfg_q.repeat_period <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bec_classify.sv
`default_nettype none

module bec_classify
  import bec_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             valid_i,
  input  wire logic             commit_i,
  input  wire logic [TimeW-1:0] time_ms_i,
  input  wire logic             level_i,
  input  wire logic             edge_seen_i,
  output decision_t             dec_o
);

  logic [TimeW-1:0] last_time_q, last_time_d;
  logic             pressed_q, pressed_d;
  logic             holding_q, holding_d;
  logic [TimeW-1:0] elapsed;
  logic             lt_click, gt_hold, gt_repeat;
  decision_t        dec;

  // Elapsed time wraps modulo 2^32
  assign elapsed   = time_ms_i - last_time_q;
  assign lt_click  = elapsed < {{(TimeW-CfgW){1'b0}}, cfg_i.click_window};
  assign gt_hold   = elapsed > {{(TimeW-CfgW){1'b0}}, cfg_i.hold_delay};
  assign gt_repeat = elapsed > {{(TimeW-CfgW){1'b0}}, cfg_i.repeat_period};

  // Decision chain, first match wins
  always_comb begin
    dec.hit   = 1'b0;
    dec.code  = EV_PRESSED;
    pressed_d = pressed_q;
    holding_d = holding_q;
    priority if (edge_seen_i && !level_i && !pressed_q) begin
      dec.hit   = 1'b1;
      dec.code  = EV_PRESSED;
      pressed_d = 1'b1;
    end else if (edge_seen_i && level_i && lt_click && !holding_q) begin
      dec.hit   = 1'b1;
      dec.code  = EV_CLICKED;
      pressed_d = 1'b0;
    end else if (edge_seen_i && level_i) begin
      dec.hit   = 1'b1;
      dec.code  = EV_RELEASED;
      pressed_d = 1'b0;
      holding_d = 1'b0;
    end else if (!level_i && !holding_q && gt_hold) begin
      dec.hit   = 1'b1;
      dec.code  = EV_HELD;
      holding_d = 1'b1;
    end else if (!level_i && holding_q && gt_repeat) begin
      dec.hit   = 1'b1;
      dec.code  = EV_REPEAT;
    end else begin
      dec.hit   = 1'b0;
    end
    dec.hit = dec.hit & valid_i;
  end

  assign last_time_d = dec.hit ? time_ms_i : last_time_q;

  // Button state, updated when the poll leaves this stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      pressed_q   <= 1'b0;
      holding_q   <= 1'b0;
    end else if (commit_i) begin
      last_time_q <= last_time_d;
      pressed_q   <= pressed_d;
      holding_q   <= holding_d;
    end
  end

  assign dec_o = dec;

  // A held event only starts a hold, a repeat only continues one
  a_held_not_holding : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec.hit && dec.code == EV_HELD |-> !holding_q)
    else $error("held event while already holding");

  a_repeat_holding : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec.hit && dec.code == EV_REPEAT |-> holding_q)
    else $error("repeat event while not holding");

  a_release_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && dec.hit && dec.code == EV_RELEASED |=> !holding_q && !pressed_q)
    else $error("release did not clear button state");

endmodule

`default_nettype wire
